FILE: rtl/dest_pkg.sv
package dest_pkg;

   // Default number of delay slots in the table.
   localparam int SLOT_COUNT_DEF = 10;

   // Fixed field widths.
   localparam int ACTION_W = 2;
   localparam int ID_W     = 15;
   localparam int DELAY_W  = 15;

   // Action codes on the request channel.
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

   // Depth of the result queue.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_SCHEDULE,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [ID_W-1:0]     event_id;
      logic [DELAY_W-1:0]  delay_ticks;
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0] fired_event;
      logic            last_of_tick;
   } rsp_type;

endpackage

FILE: rtl/dest_front.sv
module dest_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [dest_pkg::ACTION_W-1:0]     action,
   input  logic [dest_pkg::ID_W-1:0]         event_id,
   input  logic [dest_pkg::DELAY_W-1:0]      delay_ticks,
   output logic                              cmd_valid,
   output dest_pkg::cmd_type                 cmd,
   input  logic                              cmd_take
);

   // Two-entry command queue; unused action codes are dropped on entry.
   dest_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   dest_pkg::cmd_type new_cmd;
   logic              keep;
   logic              enq;
   logic              deq;

   always_comb begin
      keep                 = 1'b1;
      new_cmd.kind         = dest_pkg::CMD_TICK;
      new_cmd.event_id     = event_id;
      new_cmd.delay_ticks  = delay_ticks;
      case (action)
         dest_pkg::ACT_CLEAR:    new_cmd.kind = dest_pkg::CMD_CLEAR;
         dest_pkg::ACT_SCHEDULE: new_cmd.kind = dest_pkg::CMD_SCHEDULE;
         dest_pkg::ACT_TICK:     new_cmd.kind = dest_pkg::CMD_TICK;
         default:                keep = 1'b0;
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign enq       = push && !full && keep;
   assign deq       = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ enq;
      rd_ptr_in = rd_ptr_ff ^ deq;
      count_in  = count_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: rtl/dest_back.sv
module dest_back #(
   parameter int SLOT_COUNT = dest_pkg::SLOT_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  dest_pkg::cmd_type  cmd,
   output logic               cmd_take,
   output logic               rsp_push,
   output dest_pkg::rsp_type  rsp_data,
   input  logic               rsp_full
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                      state_ff, state_in;
   logic [SLOT_COUNT-1:0]          busy_ff, busy_in;
   logic [dest_pkg::ID_W-1:0]      event_ff  [SLOT_COUNT];
   logic [dest_pkg::DELAY_W-1:0]   remain_ff [SLOT_COUNT];
   logic [IDX_W-1:0]               walk_idx_ff, walk_idx_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [dest_pkg::ID_W-1:0]      pend_event_ff, pend_event_in;

   logic                           free_found;
   logic [IDX_W-1:0]               free_idx;
   logic                           cur_busy;
   logic                           cur_fire;
   logic                           ev_wr;
   logic                           rem_wr;
   logic [IDX_W-1:0]               wr_idx;
   logic [dest_pkg::DELAY_W-1:0]   wr_remain;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign cur_busy = busy_ff[walk_idx_ff];
   assign cur_fire = cur_busy &&
                     (remain_ff[walk_idx_ff] <= dest_pkg::DELAY_W'(1));

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      walk_idx_in   = walk_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_event_in = pend_event_ff;
      cmd_take      = 1'b0;
      rsp_push      = 1'b0;
      rsp_data.fired_event  = pend_event_ff;
      rsp_data.last_of_tick = 1'b0;
      ev_wr         = 1'b0;
      rem_wr        = 1'b0;
      wr_idx        = walk_idx_ff;
      wr_remain     = cmd.delay_ticks;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               case (cmd.kind)
                  dest_pkg::CMD_CLEAR: begin
                     busy_in = '0;
                  end
                  dest_pkg::CMD_SCHEDULE: begin
                     if (free_found) begin
                        busy_in[free_idx] = 1'b1;
                        ev_wr  = 1'b1;
                        rem_wr = 1'b1;
                        wr_idx = free_idx;
                     end
                  end
                  dest_pkg::CMD_TICK: begin
                     walk_idx_in   = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (!rsp_full) begin
               if (cur_fire) begin
                  // The previous fire is known not to be the last one.
                  busy_in[walk_idx_ff] = 1'b0;
                  rsp_push      = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_event_in = event_ff[walk_idx_ff];
               end else if (cur_busy) begin
                  rem_wr    = 1'b1;
                  wr_remain = remain_ff[walk_idx_ff] - dest_pkg::DELAY_W'(1);
               end
               if (walk_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end else begin
                  walk_idx_in = IDX_W'(walk_idx_ff + 1'b1);
               end
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_full) begin
               rsp_push              = 1'b1;
               rsp_data.last_of_tick = 1'b1;
               pend_valid_in         = 1'b0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= '0;
         walk_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         walk_idx_ff   <= walk_idx_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_event_ff <= pend_event_in;
      if (ev_wr) begin
         event_ff[wr_idx] <= cmd.event_id;
      end
      if (rem_wr) begin
         remain_ff[wr_idx] <= wr_remain;
      end
   end

endmodule

FILE: rtl/dest_rsp_queue.sv
module dest_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  dest_pkg::rsp_type  wr_data,
   output logic               q_full,
   output logic               q_empty,
   output dest_pkg::rsp_type  rd_data,
   input  logic               rd_en
);

   dest_pkg::rsp_type                 mem_ff [dest_pkg::RSP_DEPTH];
   logic [dest_pkg::RSP_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dest_pkg::RSP_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dest_pkg::RSP_PTR_W:0]      count_ff, count_in;
   logic                              enq;
   logic                              deq;

   assign q_full  = (count_ff == (dest_pkg::RSP_PTR_W + 1)'(dest_pkg::RSP_DEPTH));
   assign q_empty = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign enq     = wr_en && !q_full;
   assign deq     = rd_en && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + {{(dest_pkg::RSP_PTR_W-1){1'b0}}, enq};
      rd_ptr_in = rd_ptr_ff + {{(dest_pkg::RSP_PTR_W-1){1'b0}}, deq};
      count_in  = count_ff + {{dest_pkg::RSP_PTR_W{1'b0}}, enq}
                           - {{dest_pkg::RSP_PTR_W{1'b0}}, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/delayed_event_slot_table.sv
// Delayed event slot table.
// The request side is a queue input: drive req_action, req_event_id and
// req_delay_ticks with push high; the item is taken at a clock edge where
// full is low. A clear item frees every slot, a schedule item stores its id
// and delay in the lowest free slot (dropped when none is free), and a tick
// item counts every busy slot down, firing those whose delay is zero or one.
// The response side is a queue output: while empty is low the oldest fired
// id is on rsp_fired_event, with rsp_last_of_tick set on the final id of a
// tick; pop takes it. A tick that fires nothing returns no item.
// A two-entry command queue sits in front of the slot engine, and a
// four-entry result queue behind it. Clear and schedule are done when the
// engine takes them. A tick holds the engine while it takes the item,
// visits each slot in turn and then ends the walk in a finish step. Each
// fired id is held back in a pending register and enters the result queue
// when the walk reaches the next firing slot, or, marked as last, in the
// finish step. The walk pauses whenever the result queue is full, so a
// stalled receiver holds the engine, then the command queue, then full.
// A synchronous reset frees every slot and empties both queues.
module delayed_event_slot_table #(
   parameter int SLOT_COUNT = dest_pkg::SLOT_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [dest_pkg::ACTION_W-1:0]  req_action,
   input  logic [dest_pkg::ID_W-1:0]      req_event_id,
   input  logic [dest_pkg::DELAY_W-1:0]   req_delay_ticks,
   output logic                           empty,
   input  logic                           pop,
   output logic [dest_pkg::ID_W-1:0]      rsp_fired_event,
   output logic                           rsp_last_of_tick
);

   // Command path between the front queue and the slot engine.
   logic              cmd_valid;
   dest_pkg::cmd_type cmd;
   logic              cmd_take;

   // Result path between the slot engine and the result queue.
   logic              rsp_push;
   dest_pkg::rsp_type rsp_in_data;
   logic              rsp_full;
   dest_pkg::rsp_type rsp_out_data;

   dest_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .action      (req_action),
      .event_id    (req_event_id),
      .delay_ticks (req_delay_ticks),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   dest_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in_data),
      .rsp_full  (rsp_full)
   );

   dest_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_in_data),
      .q_full  (rsp_full),
      .q_empty (empty),
      .rd_data (rsp_out_data),
      .rd_en   (pop)
   );

   assign rsp_fired_event  = rsp_out_data.fired_event;
   assign rsp_last_of_tick = rsp_out_data.last_of_tick;

`ifndef SYNTHESIS
   // The engine never writes into a full result queue.
   assert property (@(posedge clock) disable iff (reset) rsp_push |-> !rsp_full)
      else $error("result written while result queue full");

   // The engine only takes a command that is present.
   assert property (@(posedge clock) disable iff (reset) cmd_take |-> cmd_valid)
      else $error("command taken from empty command queue");

   // Reset leaves no result waiting.
   assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");
`endif

endmodule

FILE: tb/tb_delayed_event_slot_table.sv
`timescale 1ns / 1ps

module tb_delayed_event_slot_table;

   // Table size and timing figures used by the testbench.
   localparam int NSLOT = dest_pkg::SLOT_COUNT_DEF;
   localparam int AW    = dest_pkg::ACTION_W;
   localparam int IW    = dest_pkg::ID_W;
   localparam int DW    = dest_pkg::DELAY_W;
   // The fourth action code is unused by the block and must be ignored.
   localparam logic [AW-1:0] ACT_UNUSED = 2'd3;
   // A tick holds the engine while it walks every slot, and both queues
   // add their own delay.
   localparam int SETTLE_CYCLES = 2 * NSLOT + 20;
   localparam int RANDOM_ITEMS  = 105;
   localparam int HOLD_CYCLES   = 300;
   localparam int END_LIMIT     = 50000;

   logic            clock = 1'b0;
   logic            reset;
   logic            push;
   logic            full;
   logic [AW-1:0]   req_action;
   logic [IW-1:0]   req_event_id;
   logic [DW-1:0]   req_delay_ticks;
   logic            empty;
   logic            pop;
   logic [IW-1:0]   rsp_fired_event;
   logic            rsp_last_of_tick;

   delayed_event_slot_table dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_action      (req_action),
      .req_event_id    (req_event_id),
      .req_delay_ticks (req_delay_ticks),
      .empty           (empty),
      .pop             (pop),
      .rsp_fired_event (rsp_fired_event),
      .rsp_last_of_tick(rsp_last_of_tick)
   );

   // One fired event as it should leave the result channel.
   typedef struct {
      logic [IW-1:0] id;
      logic          last;
   } fired_type;

   // One row of the directed table. When typed is set the expected outcome
   // is written into the row itself: either no item at all, or exactly one
   // item carrying typed_id with the last-of-tick mark.
   typedef struct {
      logic [AW-1:0] act;
      logic [IW-1:0] id;
      logic [DW-1:0] dly;
      bit            typed;
      bit            typed_fire;
      logic [IW-1:0] typed_id;
   } dir_row_type;

   // The testbench's own copy of the slot table.
   bit            slot_taken [NSLOT];
   logic [IW-1:0] slot_id    [NSLOT];
   logic [15:0]   slot_left  [NSLOT];

   // Events that the table has fired and the receiver has not yet seen.
   fired_type   fired_due_q[$];
   dir_row_type dir_rows[$];

   int err_cnt     = 0;
   int burst_left  = 0;
   bit hold_req    = 1'b0;
   int hold_left   = 0;

   // Free-running clock with a 10 ns period.
   always #5 clock = ~clock;

   // Hard stop in case the block hangs. The slowest legal run is far shorter.
   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   // Applies one item to the slot table copy. When record is set, every event
   // that fires is queued as due. Returns the number of fired events for a
   // tick, zero for clear or a stored schedule, and -1 when the item has no
   // effect at all (a schedule into a full table, or the unused action).
   function automatic int advance_slots(input logic [AW-1:0] act,
                                        input logic [IW-1:0] ev,
                                        input logic [DW-1:0] dly,
                                        input bit record);
      int        i;
      int        fired;
      fired_type f;
      fired = 0;
      case (act)
         dest_pkg::ACT_CLEAR: begin
            for (i = 0; i < NSLOT; i++) slot_taken[i] = 1'b0;
            return 0;
         end
         dest_pkg::ACT_SCHEDULE: begin
            // The lowest free slot takes the event.
            for (i = 0; i < NSLOT; i++) begin
               if (!slot_taken[i]) begin
                  slot_taken[i] = 1'b1;
                  slot_id[i]    = ev;
                  slot_left[i]  = {1'b0, dly};
                  return 0;
               end
            end
            return -1;
         end
         dest_pkg::ACT_TICK: begin
            // Slots are visited in ascending order, which is also the order
            // in which their events leave the block.
            for (i = 0; i < NSLOT; i++) begin
               if (slot_taken[i]) begin
                  if (slot_left[i] <= 16'd1) begin
                     slot_taken[i] = 1'b0;
                     slot_left[i]  = 16'd0;
                     fired++;
                     if (record) begin
                        f.id   = slot_id[i];
                        f.last = 1'b0;
                        fired_due_q.push_back(f);
                     end
                  end else begin
                     slot_left[i] = slot_left[i] - 16'd1;
                  end
               end
            end
            if (record && fired > 0) fired_due_q[fired_due_q.size()-1].last = 1'b1;
            return fired;
         end
         default: begin
            return -1;
         end
      endcase
   endfunction

   function automatic dir_row_type dir_row(input logic [AW-1:0] act,
                                           input logic [IW-1:0] id,
                                           input logic [DW-1:0] dly,
                                           input bit typed,
                                           input bit typed_fire,
                                           input logic [IW-1:0] typed_id);
      dir_row_type r;
      r.act        = act;
      r.id         = id;
      r.dly        = dly;
      r.typed      = typed;
      r.typed_fire = typed_fire;
      r.typed_id   = typed_id;
      return r;
   endfunction

   // Drops push for an idle gap whose length is given by n (n is at least one).
   task automatic idle_gap(input int n);
      @(negedge clock);
      push <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // The sender works in bursts. A burst is usually short, but now and then
   // a long one gives a stretch with no idling at all.
   task automatic pace();
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 50);
         else burst_left = $urandom_range(1, 8);
         idle_gap($urandom_range(1, 12));
      end
      burst_left--;
   endtask

   // Offers one item and waits until the block takes it. The item is applied
   // to the table copy at the clock edge where it is accepted.
   task automatic offer(input logic [AW-1:0] act,
                        input logic [IW-1:0] id,
                        input logic [DW-1:0] dly,
                        input bit record,
                        output int outcome);
      @(negedge clock);
      push            <= 1'b1;
      req_action      <= act;
      req_event_id    <= id;
      req_delay_ticks <= dly;
      do @(posedge clock); while (full);
      outcome = advance_slots(act, id, dly, record);
   endtask

   // Waits until every due event has come back, then lets the block settle,
   // since clears and schedules give no item that would show they are done.
   task automatic drain();
      idle_gap(1);
      while (fired_due_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   // Receiver. Pop follows a pattern that changes from segment to segment,
   // and a hold request from the sender freezes it for a long stretch so
   // that the result queue and then the request side fill up.
   initial begin
      int        seg_left;
      int        seg_mode;
      int        rx_cnt;
      bit        want;
      fired_type exp_item;
      seg_left = 0;
      seg_mode = 0;
      rx_cnt   = 0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(10, 60);
            seg_mode = $urandom_range(0, 3);
         end
         seg_left--;
         rx_cnt++;
         case (seg_mode)
            0: want = 1'b1;
            1: want = (rx_cnt % 3) != 0;
            2: want = 1'($urandom_range(0, 1));
            default: want = (rx_cnt % 8) < 2;
         endcase
         if (hold_left > 0) begin
            hold_left--;
            want = 1'b0;
         end
         pop <= want;
         @(posedge clock);
         if (pop && !empty) begin
            if (fired_due_q.size() == 0) begin
               err_cnt++;
               $display("%0t: unexpected item, expected none, actual %h last_of_tick %b",
                        $realtime, rsp_fired_event, rsp_last_of_tick);
            end else begin
               exp_item = fired_due_q.pop_front();
               if (rsp_fired_event !== exp_item.id) begin
                  err_cnt++;
                  $display("%0t: fired_event expected %h actual %h",
                           $realtime, exp_item.id, rsp_fired_event);
               end
               if (rsp_last_of_tick !== exp_item.last) begin
                  err_cnt++;
                  $display("%0t: last_of_tick expected %b actual %b",
                           $realtime, exp_item.last, rsp_last_of_tick);
               end
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int            i;
      int            k;
      int            outcome;
      int            taken;
      int            pick;
      int            waited;
      bit            pressed;
      bit            paused;
      fired_type     f;
      dir_row_type   row;
      logic [AW-1:0] act;
      logic [IW-1:0] id;
      logic [DW-1:0] dly;

      reset           = 1'b1;
      push            = 1'b0;
      pop             = 1'b0;
      req_action      = dest_pkg::ACT_CLEAR;
      req_event_id    = '0;
      req_delay_ticks = '0;
      for (i = 0; i < NSLOT; i++) begin
         slot_taken[i] = 1'b0;
         slot_id[i]    = '0;
         slot_left[i]  = '0;
      end

      // Directed part. A tick right after reset finds every slot free.
      dir_rows.push_back(dir_row(dest_pkg::ACT_TICK, 15'h0000, 15'h0000,
                                 1'b1, 1'b0, 15'h0000));
      // A delay of zero fires on the very next tick, as does a delay of one.
      dir_rows.push_back(dir_row(dest_pkg::ACT_SCHEDULE, 15'h0000, 15'h0000,
                                 1'b1, 1'b0, 15'h0000));
      dir_rows.push_back(dir_row(dest_pkg::ACT_TICK, 15'h7FFF, 15'h7FFF,
                                 1'b1, 1'b1, 15'h0000));
      // The top event id is stored like any other.
      dir_rows.push_back(dir_row(dest_pkg::ACT_SCHEDULE, 15'h7FFF, 15'h0001,
                                 1'b1, 1'b0, 15'h0000));
      dir_rows.push_back(dir_row(dest_pkg::ACT_TICK, 15'h0000, 15'h0000,
                                 1'b1, 1'b1, 15'h7FFF));
      // The unused action must change nothing, so the next tick is empty.
      dir_rows.push_back(dir_row(ACT_UNUSED, 15'h7FFF, 15'h7FFF,
                                 1'b1, 1'b0, 15'h0000));
      dir_rows.push_back(dir_row(dest_pkg::ACT_TICK, 15'h0000, 15'h0000,
                                 1'b1, 1'b0, 15'h0000));
      // Fill all slots with a mix of short and very long delays.
      for (i = 0; i < NSLOT; i++) begin
         case (i % 5)
            0: dly = 15'd2;
            1: dly = 15'h7FFF;
            2: dly = 15'd3;
            3: dly = 15'd1;
            default: dly = 15'h7FFE;
         endcase
         dir_rows.push_back(dir_row(dest_pkg::ACT_SCHEDULE,
                                    15'h2A55 ^ (15'(i) << (i % 11)), dly,
                                    1'b0, 1'b0, 15'h0000));
      end
      // With the table full this schedule is dropped.
      dir_rows.push_back(dir_row(dest_pkg::ACT_SCHEDULE, 15'h1234, 15'h0000,
                                 1'b1, 1'b0, 15'h0000));
      dir_rows.push_back(dir_row(dest_pkg::ACT_TICK, 15'h0000, 15'h0000,
                                 1'b0, 1'b0, 15'h0000));
      dir_rows.push_back(dir_row(dest_pkg::ACT_TICK, 15'h0000, 15'h0000,
                                 1'b0, 1'b0, 15'h0000));
      // A clear frees every slot, the long ones too.
      dir_rows.push_back(dir_row(dest_pkg::ACT_CLEAR, 15'h7FFF, 15'h7FFF,
                                 1'b1, 1'b0, 15'h0000));
      dir_rows.push_back(dir_row(dest_pkg::ACT_TICK, 15'h0000, 15'h0000,
                                 1'b1, 1'b0, 15'h0000));
      // Slot zero is reused after the clear; delay two needs two ticks.
      dir_rows.push_back(dir_row(dest_pkg::ACT_SCHEDULE, 15'h0007, 15'h0002,
                                 1'b1, 1'b0, 15'h0000));
      dir_rows.push_back(dir_row(dest_pkg::ACT_TICK, 15'h0000, 15'h0000,
                                 1'b1, 1'b0, 15'h0000));
      dir_rows.push_back(dir_row(dest_pkg::ACT_TICK, 15'h0000, 15'h0000,
                                 1'b1, 1'b1, 15'h0007));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         row = dir_rows[r];
         pace();
         offer(row.act, row.id, row.dly, !row.typed, outcome);
         if (row.typed && row.typed_fire) begin
            f.id   = row.typed_id;
            f.last = 1'b1;
            fired_due_q.push_back(f);
         end
      end
      drain();

      // Random part. Schedules and ticks dominate so that the table keeps
      // filling and firing; clears and the unused action are rare noise.
      // Most delays are short so that events come back within a few ticks.
      taken   = 0;
      pressed = 1'b0;
      paused  = 1'b0;
      while (taken < RANDOM_ITEMS) begin
         if (!pressed && taken >= RANDOM_ITEMS / 2) begin
            // Receiver holds off while the sender keeps offering two full
            // loads of immediate events, so the block has to stall its input.
            pressed  = 1'b1;
            hold_req = 1'b1;
            for (k = 0; k < 2 * (NSLOT + 1); k++) begin
               if (k % (NSLOT + 1) == NSLOT)
                  offer(dest_pkg::ACT_TICK, IW'($urandom), DW'($urandom), 1'b1, outcome);
               else
                  offer(dest_pkg::ACT_SCHEDULE, IW'($urandom), 15'h0000, 1'b1, outcome);
            end
         end
         if (!paused && taken >= (3 * RANDOM_ITEMS) / 4) begin
            paused = 1'b1;
            drain();
         end

         pick = $urandom_range(0, 99);
         id   = IW'($urandom);
         dly  = DW'($urandom);
         if (pick < 5) act = dest_pkg::ACT_CLEAR;
         else if (pick < 9) act = ACT_UNUSED;
         else if (pick < 59) act = dest_pkg::ACT_SCHEDULE;
         else act = dest_pkg::ACT_TICK;
         if (act == dest_pkg::ACT_SCHEDULE) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) dly = DW'($urandom_range(0, 6));
            else if (pick < 85) dly = DW'($urandom_range(7, 40));
            else if (pick < 95) dly = DW'($urandom_range(0, 32767));
            else dly = 15'h7FFF;
         end
         pace();
         offer(act, id, dly, 1'b1, outcome);
         if (outcome >= 0) taken++;
      end

      // Let every due event come back, then give the block time to show
      // anything extra it might still send.
      idle_gap(1);
      waited = 0;
      while (fired_due_q.size() != 0 && waited < END_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fired_due_q.size() != 0) begin
         err_cnt++;
         $display("%0t: %0d fired events never came out, oldest expected %h actual none",
                  $realtime, fired_due_q.size(), fired_due_q[0].id);
      end

      if (err_cnt == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/dest_pkg.sv
rtl/dest_front.sv
rtl/dest_back.sv
rtl/dest_rsp_queue.sv
rtl/delayed_event_slot_table.sv
tb/tb_delayed_event_slot_table.sv
